// ----- src/ufds_pkg.sv -----
// Package for the UDS flash download server: result and job types, result kinds,
// config indices and reset values, service and response codes. No dependencies.
package ufds_pkg;

	typedef enum logic [2:0] {
		KIND_FRAME = 3'd0,
		KIND_ERASE = 3'd1,
		KIND_WRITE = 3'd2,
		KIND_JUMP  = 3'd3,
		KIND_RESET = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		CFG_REQ_ID   = 3'd0,
		CFG_RSP_ID   = 3'd1,
		CFG_BASE     = 3'd2,
		CFG_END      = 3'd3,
		CFG_TIMEOUT  = 3'd4
	} cfg_idx_t;

	localparam logic [7:0] SID_SESSION  = 8'h10;
	localparam logic [7:0] SID_ECU_RST  = 8'h11;
	localparam logic [7:0] SID_READ_DID = 8'h22;
	localparam logic [7:0] SID_WRITE_DID = 8'h2E;
	localparam logic [7:0] SID_REQ_DL   = 8'h34;
	localparam logic [7:0] SID_XFER     = 8'h36;
	localparam logic [7:0] SID_EXIT     = 8'h37;

	localparam logic [7:0] NRC_NOT_SUPP = 8'h11;
	localparam logic [7:0] NRC_SUBFUNC  = 8'h12;
	localparam logic [7:0] NRC_LENGTH   = 8'h13;
	localparam logic [7:0] NRC_SEQUENCE = 8'h24;
	localparam logic [7:0] NRC_RANGE    = 8'h31;
	localparam logic [7:0] NRC_PROGRAM  = 8'h72;
	localparam logic [7:0] NRC_BLOCK    = 8'h73;
	localparam logic [7:0] NEG_SID      = 8'h7F;

	localparam logic [10:0] REQ_ID_RST  = 11'h7E0;
	localparam logic [10:0] RSP_ID_RST  = 11'h7E8;
	localparam logic [31:0] BASE_RST    = 32'h0001_0000;
	localparam logic [31:0] END_RST     = 32'h0008_0000;
	localparam logic [15:0] TIMEOUT_RST = 16'd5000;

	localparam int NRES = 3;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] data;
		logic [31:0] addr;
		logic [15:0] elen;
		logic [10:0] id;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t [NRES-1:0] res;
	} job_t;

endpackage

// ----- src/ufds_front.sv -----
// Front part: accepts frames and ticks, keeps the download state and the session
// timer, and builds the result list of each item. Depends on ufds_pkg.
module ufds_front #(
	parameter int FLASH_WORD_BYTES = 8,
	parameter int MAX_BLOCK_BYTES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             accept,
	input  logic             operation,
	input  logic [10:0]      frame_id,
	input  logic [3:0]       frame_len,
	input  logic [63:0]      frame_bytes,
	input  logic             flash_fail,
	input  logic [31:0]      region_crc,
	output logic             push,
	output ufds_pkg::job_t   job
);
	import ufds_pkg::*;

	localparam int WORD_B = (FLASH_WORD_BYTES > 8) ? 8 :
		((FLASH_WORD_BYTES < 4) ? 4 : FLASH_WORD_BYTES);
	localparam int BLOCK_B = (MAX_BLOCK_BYTES > 5) ? 5 :
		((MAX_BLOCK_BYTES < 0) ? 0 : MAX_BLOCK_BYTES);
	localparam logic [3:0] WORD_B4 = 4'(WORD_B);
	localparam logic [7:0] BLOCK_ADV = 8'(MAX_BLOCK_BYTES);

	logic [10:0] req_id_q, rsp_id_q;
	logic [31:0] base_q, end_q;
	logic [15:0] timeout_q;

	logic        active_q, guard_q;
	logic [31:0] start_q, waddr_q;
	logic [15:0] total_q, timer_q;
	logic [7:0]  block_q;
	logic [3:0]  count_q;
	logic [7:0]  stage_q [8];

	logic        active_d, guard_d;
	logic [31:0] start_d, waddr_d;
	logic [15:0] total_d, timer_d;
	logic [7:0]  block_d;
	logic [3:0]  count_d;
	logic [7:0]  stage_d [8];

	res_t        res_v [4];
	logic [1:0]  n_v;

	function automatic res_t frame_res(input logic [63:0] d, input logic [10:0] id);
		res_t r;
		r.kind = KIND_FRAME;
		r.data = d;
		r.addr = '0;
		r.elen = '0;
		r.id = id;
		return r;
	endfunction

	function automatic res_t plain_res(input kind_t k);
		res_t r;
		r.kind = k;
		r.data = '0;
		r.addr = '0;
		r.elen = '0;
		r.id = '0;
		return r;
	endfunction

	always_comb begin
		logic [7:0]  b [8];
		logic [3:0]  len;
		logic [7:0]  sid;
		logic [31:0] addr;
		logic [15:0] size;
		logic [3:0]  cnt;
		logic        bad;
		logic [63:0] wdata;
		logic [7:0]  nrc;
		logic        is_neg;
		for (int j = 0; j < 8; j++) begin
			b[j] = frame_bytes[63-8*j -: 8];
		end
		len = b[0][3:0];
		sid = b[1];
		addr = {b[2], b[3], b[4], b[5]};
		size = {b[6], b[7]};
		cnt = '0;
		bad = 1'b0;
		wdata = '0;
		nrc = '0;
		is_neg = 1'b0;
		active_d = active_q;
		guard_d = guard_q;
		start_d = start_q;
		waddr_d = waddr_q;
		total_d = total_q;
		timer_d = timer_q;
		block_d = block_q;
		count_d = count_q;
		stage_d = stage_q;
		for (int k = 0; k < 4; k++) begin
			res_v[k] = plain_res(KIND_FRAME);
		end
		n_v = '0;
		if (operation) begin
			if (timer_q != '0) begin
				timer_d = timer_q - 16'd1;
				if (timer_d == '0) begin
					if (!guard_q) begin
						res_v[0] = plain_res(KIND_JUMP);
						n_v = 2'd1;
					end
					timer_d = timeout_q;
				end
			end
		end else if (frame_id == req_id_q && frame_len >= 4'd2) begin
			timer_d = timeout_q;
			unique case (sid)
				SID_SESSION: begin
					if (len != 4'd2) begin
						is_neg = 1'b1; nrc = NRC_LENGTH;
					end else if (b[2] != 8'h01 && b[2] != 8'h03) begin
						is_neg = 1'b1; nrc = NRC_SUBFUNC;
					end else begin
						res_v[0] = frame_res({8'h06, 8'h50, b[2], 8'h00, 8'h32, 8'h01,
							8'hF4, 8'h00}, rsp_id_q);
						n_v = 2'd1;
					end
				end
				SID_ECU_RST: begin
					if (len != 4'd2) begin
						is_neg = 1'b1; nrc = NRC_LENGTH;
					end else if (b[2] != 8'h01) begin
						is_neg = 1'b1; nrc = NRC_SUBFUNC;
					end else begin
						res_v[0] = frame_res({8'h02, 8'h51, 8'h01, 40'h0}, rsp_id_q);
						res_v[1] = plain_res(KIND_RESET);
						n_v = 2'd2;
					end
				end
				SID_READ_DID: begin
					if (len != 4'd3) begin
						is_neg = 1'b1; nrc = NRC_LENGTH;
					end else if (b[2] != 8'hF1 || b[3] != 8'h89) begin
						is_neg = 1'b1; nrc = NRC_RANGE;
					end else begin
						res_v[0] = frame_res(64'h0762_F189_5631_2E30, rsp_id_q);
						n_v = 2'd1;
					end
				end
				SID_WRITE_DID: begin
					if (len != 4'd7) begin
						is_neg = 1'b1; nrc = NRC_LENGTH;
					end else if (b[2] != 8'hFF || b[3] != 8'h01) begin
						is_neg = 1'b1; nrc = NRC_RANGE;
					end else if (active_q || total_q == '0) begin
						is_neg = 1'b1; nrc = NRC_SEQUENCE;
					end else if ({b[4], b[5], b[6], b[7]} != region_crc) begin
						is_neg = 1'b1; nrc = NRC_PROGRAM;
					end else begin
						res_v[0] = frame_res({8'h04, 8'h6E, 8'hFF, 8'h01, 32'h0}, rsp_id_q);
						res_v[1] = plain_res(KIND_JUMP);
						n_v = 2'd2;
					end
				end
				SID_REQ_DL: begin
					if (len < 4'd7) begin
						is_neg = 1'b1; nrc = NRC_LENGTH;
					end else if (addr < base_q || size == '0 ||
						({1'b0, addr} + {17'b0, size}) > {1'b0, end_q}) begin
						is_neg = 1'b1; nrc = NRC_RANGE;
					end else begin
						res_v[0] = plain_res(KIND_ERASE);
						res_v[0].addr = addr;
						res_v[0].elen = size;
						n_v = 2'd1;
						if (flash_fail) begin
							is_neg = 1'b1; nrc = NRC_PROGRAM;
						end else begin
							active_d = 1'b1;
							start_d = addr;
							waddr_d = addr;
							total_d = size;
							block_d = 8'd1;
							count_d = '0;
							guard_d = 1'b1;
							res_v[1] = frame_res({8'h04, 8'h74, 8'h20, 8'h04, BLOCK_ADV, 24'h0},
								rsp_id_q);
							n_v = 2'd2;
						end
					end
				end
				SID_XFER: begin
					if (!active_q) begin
						is_neg = 1'b1; nrc = NRC_SEQUENCE;
					end else if (b[2] != block_q) begin
						is_neg = 1'b1; nrc = NRC_BLOCK;
					end else if (len < 4'd2) begin
						is_neg = 1'b1; nrc = NRC_LENGTH;
					end else begin
						cnt = len - 4'd2;
						if (cnt > 4'(BLOCK_B)) cnt = 4'(BLOCK_B);
						for (int i = 0; i < BLOCK_B; i++) begin
							if (!bad && 4'(i) < cnt) begin
								stage_d[count_d[2:0]] = b[3+i];
								count_d = count_d + 4'd1;
								if (count_d >= WORD_B4) begin
									for (int j = 0; j < 8; j++) begin
										wdata[63-8*j -: 8] = (j < WORD_B) ? stage_d[j] : 8'h00;
									end
									res_v[n_v] = plain_res(KIND_WRITE);
									res_v[n_v].data = wdata;
									res_v[n_v].addr = waddr_d;
									n_v = n_v + 2'd1;
									if (flash_fail) begin
										bad = 1'b1;
									end else begin
										waddr_d = waddr_d + 32'(WORD_B);
										count_d = '0;
									end
								end
							end
						end
						if (bad) begin
							is_neg = 1'b1; nrc = NRC_PROGRAM;
							active_d = 1'b0;
						end else begin
							block_d = (block_q == 8'hFF) ? 8'd1 : block_q + 8'd1;
							res_v[n_v] = frame_res({8'h02, 8'h76, b[2], 40'h0}, rsp_id_q);
							n_v = n_v + 2'd1;
						end
					end
				end
				SID_EXIT: begin
					if (!active_q) begin
						is_neg = 1'b1; nrc = NRC_SEQUENCE;
					end else begin
						if (count_q != '0) begin
							for (int j = 0; j < 8; j++) begin
								if (4'(j) >= count_q && j < WORD_B) stage_d[j] = 8'hFF;
								wdata[63-8*j -: 8] = (j < WORD_B) ? stage_d[j] : 8'h00;
							end
							res_v[0] = plain_res(KIND_WRITE);
							res_v[0].data = wdata;
							res_v[0].addr = waddr_q;
							n_v = 2'd1;
							if (flash_fail) bad = 1'b1;
							else count_d = '0;
						end
						active_d = 1'b0;
						if (bad) begin
							is_neg = 1'b1; nrc = NRC_PROGRAM;
						end else begin
							guard_d = 1'b0;
							res_v[n_v] = frame_res({8'h01, 8'h77, 48'h0}, rsp_id_q);
							n_v = n_v + 2'd1;
						end
					end
				end
				default: begin
					is_neg = 1'b1; nrc = NRC_NOT_SUPP;
				end
			endcase
			if (is_neg) begin
				res_v[n_v] = frame_res({8'h03, NEG_SID, sid, nrc, 32'h0}, rsp_id_q);
				n_v = n_v + 2'd1;
			end
		end
	end

	assign push = accept && (n_v != '0);

	always_comb begin
		job.cnt = n_v;
		for (int k = 0; k < NRES; k++) begin
			job.res[k] = res_v[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_id_q <= REQ_ID_RST;
			rsp_id_q <= RSP_ID_RST;
			base_q <= BASE_RST;
			end_q <= END_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_REQ_ID:  req_id_q <= cfg_data[10:0];
				CFG_RSP_ID:  rsp_id_q <= cfg_data[10:0];
				CFG_BASE:    base_q <= cfg_data;
				CFG_END:     end_q <= cfg_data;
				CFG_TIMEOUT: timeout_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			guard_q <= 1'b0;
			start_q <= '0;
			waddr_q <= '0;
			total_q <= '0;
			timer_q <= TIMEOUT_RST;
			block_q <= 8'd1;
			count_q <= '0;
		end else if (accept) begin
			active_q <= active_d;
			guard_q <= guard_d;
			start_q <= start_d;
			waddr_q <= waddr_d;
			total_q <= total_d;
			timer_q <= timer_d;
			block_q <= block_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) stage_q <= stage_d;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= WORD_B4) else $error("staged byte count beyond flash word");
	a_exit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !operation && push && !active_d |=> !active_q)
		else $error("download state not updated");
	a_block_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		block_q != '0) else $error("block counter reached zero");
`endif

endmodule

// ----- src/ufds_queue.sv -----
// Two-entry job queue between the front and back parts of the UDS download server.
// Depends on ufds_pkg.
module ufds_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ufds_pkg::job_t   wr_job,
	input  logic             pop,
	output ufds_pkg::job_t   rd_job,
	output logic             full,
	output logic             empty
);
	import ufds_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] level_q;

	assign full = (level_q == 2'd2);
	assign empty = (level_q == 2'd0);
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			level_q <= level_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_job;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("pop from empty queue");
	a_ptr_level: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q == rd_ptr_q) == (level_q != 2'd1)) else $error("queue pointers disagree");
`endif

endmodule

// ----- src/ufds_back.sv -----
// Back part: takes jobs from the queue and delivers their results one beat at a
// time through an output register. Depends on ufds_pkg.
module ufds_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ufds_pkg::job_t   head,
	input  logic             empty,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output ufds_pkg::res_t   out_res,
	output logic             out_last
);
	import ufds_pkg::*;

	logic       valid_q;
	logic [1:0] idx_q;
	logic       load, is_last;
	res_t       sel;
	res_t       res_q;
	logic       last_q;

	always_comb begin
		case (idx_q)
			2'd0:    sel = head.res[0];
			2'd1:    sel = head.res[1];
			default: sel = head.res[2];
		endcase
	end

	assign load = !empty && (!valid_q || !out_stall);
	assign is_last = (idx_q + 2'd1 == head.cnt);
	assign pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= sel;
			last_q <= is_last;
		end
	end

	assign out_valid = valid_q;
	assign out_res = res_q;
	assign out_last = last_q;

`ifndef SYNTHESIS
	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> idx_q < head.cnt) else $error("result index beyond job");
	a_idx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == '0) else $error("index not cleared after job");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_stall |=> valid_q) else $error("result dropped while stalled");
`endif

endmodule

// ----- src/uds_flash_download_server.sv -----
// Top level of the UDS single-frame flash download server.
// Instantiates ufds_front, ufds_queue and ufds_back; depends on ufds_pkg.
//
// Channel | Direction | Handshake            | Payload
// in      | sink      | in_valid / in_stall   | operation, frame_id, frame_len, frame_bytes,
//         |           |                      | flash_fail, region_crc
// out     | source    | out_valid / out_stall | result_kind, data_word, flash_address,
//         |           |                      | erase_length, tx_can_id, last
// cfg     | sink      | cfg_write            | cfg_index, cfg_data
//
// An item is taken by the front part whenever the two-entry job queue has room;
// each result of a job (one to three) then leaves the output register one per
// cycle while out_stall is low, and the output register holds it while stalled.
// Reset clears all control state and loads the register reset values.
// A stalled output fills the queue, after which in_stall rises.
module uds_flash_download_server #(
	parameter int FLASH_WORD_BYTES = 8,
	parameter int MAX_BLOCK_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [10:0] frame_id,
	input  logic [3:0]  frame_len,
	input  logic [63:0] frame_bytes,
	input  logic        flash_fail,
	input  logic [31:0] region_crc,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [63:0] data_word,
	output logic [31:0] flash_address,
	output logic [15:0] erase_length,
	output logic [10:0] tx_can_id,
	output logic        last
);
	import ufds_pkg::*;

	logic accept, push, pop, full, empty;
	job_t wr_job, head;
	res_t res;

	assign in_stall = full;
	assign accept = in_valid && !full;

	ufds_front #(
		.FLASH_WORD_BYTES(FLASH_WORD_BYTES),
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.accept(accept), .operation(operation), .frame_id(frame_id),
		.frame_len(frame_len), .frame_bytes(frame_bytes), .flash_fail(flash_fail),
		.region_crc(region_crc), .push(push), .job(wr_job)
	);

	ufds_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_job(wr_job), .pop(pop),
		.rd_job(head), .full(full), .empty(empty)
	);

	ufds_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .empty(empty), .pop(pop),
		.out_stall(out_stall), .out_valid(out_valid), .out_res(res), .out_last(last)
	);

	assign result_kind = res.kind;
	assign data_word = res.data;
	assign flash_address = res.addr;
	assign erase_length = res.elen;
	assign tx_can_id = res.id;

endmodule
